FILE: hdl/cbsu_pkg.sv
// Shared types, codes and helpers for the CB-prefix bit and shift unit.
package cbsu_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [2:0] REG_H   = 3'd4;
  localparam logic [2:0] REG_L   = 3'd5;
  localparam logic [2:0] REG_MEM = 3'd6;

  localparam int FLAG_Z = 3;
  localparam int FLAG_N = 2;
  localparam int FLAG_H = 1;
  localparam int FLAG_C = 0;

  localparam logic [4:0] CYC_LOAD    = 5'd0;
  localparam logic [4:0] CYC_REG     = 5'd8;
  localparam logic [4:0] CYC_BIT_MEM = 5'd12;
  localparam logic [4:0] CYC_MEM     = 5'd16;

  typedef enum logic [1:0] {
    GRP_SHIFT = 2'd0,
    GRP_BIT   = 2'd1,
    GRP_RES   = 2'd2,
    GRP_SET   = 2'd3
  } group_t;

  typedef enum logic [2:0] {
    SH_RLC  = 3'd0,
    SH_RRC  = 3'd1,
    SH_RL   = 3'd2,
    SH_RR   = 3'd3,
    SH_SLA  = 3'd4,
    SH_SRA  = 3'd5,
    SH_SWAP = 3'd6,
    SH_SRL  = 3'd7
  } shift_t;

  typedef enum logic {
    OP_EXEC = 1'b0,
    OP_LOAD = 1'b1
  } op_t;

  typedef struct packed {
    logic       op;
    logic [7:0] opcode;
    logic [2:0] reg_index;
    logic [7:0] reg_value;
    logic [7:0] mem_data;
  } request_t;

  // classified beat handed from front to back
  typedef struct packed {
    logic       is_load;
    logic [2:0] load_idx;
    logic [7:0] load_val;
    group_t     group;
    logic [2:0] bitn;
    logic [2:0] sel;
    logic       is_mem;
    logic [7:0] mem_data;
  } decoded_t;

  typedef struct packed {
    logic [7:0]  result_value;
    logic [3:0]  flags;
    logic        mem_write;
    logic [15:0] mem_address;
    logic [4:0]  cycles;
  } result_t;

  // returns {carry_out, result}
  function automatic logic [8:0] shift_op(input logic [2:0] kind, input logic [7:0] v,
                                          input logic cin);
    logic [8:0] r;
    case (shift_t'(kind))
      SH_RLC:  r = {v[7], v[6:0], v[7]};
      SH_RRC:  r = {v[0], v[0], v[7:1]};
      SH_RL:   r = {v[7], v[6:0], cin};
      SH_RR:   r = {v[0], cin, v[7:1]};
      SH_SLA:  r = {v[7], v[6:0], 1'b0};
      SH_SRA:  r = {v[0], v[7], v[7:1]};
      SH_SWAP: r = {1'b0, v[3:0], v[7:4]};
      SH_SRL:  r = {v[0], 1'b0, v[7:1]};
      default: r = {1'b0, v};
    endcase
    return r;
  endfunction

endpackage

FILE: hdl/cb_prefix_bit_shift_unit.sv
// Top level of the CB-prefix bit and shift unit.
// Takes one request beat per cycle while full is low and returns one result beat per request,
// in order. A request enters the front queue at the accepting edge, is executed by the back
// end once it heads that queue and the result queue has room (one register-file read and
// write per cycle, so dependent requests follow each other with no bubble) and is shown on
// the result ports from the edge that ends its execution cycle. full rises only when both
// the front queue and the result queue (QUEUE_DEPTH beats each) are filled by a stalled
// result side.
module cb_prefix_bit_shift_unit #(
  parameter int QUEUE_DEPTH = cbsu_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  cbsu_pkg::request_t request,
  output logic               full,
  output logic               empty,
  input  logic               pop,
  output cbsu_pkg::result_t  result
);

  cbsu_pkg::decoded_t decoded;
  cbsu_pkg::result_t  exec_data;
  logic               none;
  logic               take;
  logic               out_full;
  logic               out_push;

  cbsu_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .request (request),
    .full    (full),
    .take    (take),
    .decoded (decoded),
    .none    (none)
  );

  cbsu_back u_back (
    .clk      (clk),
    .rst      (rst),
    .decoded  (decoded),
    .none     (none),
    .take     (take),
    .out_full (out_full),
    .out_push (out_push),
    .out_data (exec_data)
  );

  cbsu_fifo #(
    .item_t (cbsu_pkg::result_t),
    .DEPTH  (QUEUE_DEPTH)
  ) u_result_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (out_push),
    .wr_data (exec_data),
    .full    (out_full),
    .pop     (pop),
    .rd_data (result),
    .empty   (empty)
  );

endmodule

FILE: hdl/cbsu_fifo.sv
// Small register queue used between front and back and at the result side.
module cbsu_fifo #(
  parameter type item_t = logic,
  parameter int  DEPTH  = cbsu_pkg::QUEUE_DEPTH
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t wr_data,
  output logic  full,
  input  logic  pop,
  output item_t rd_data,
  output logic  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t             mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push;
  logic              do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: hdl/cbsu_front.sv
// Front end: takes request beats, classifies them and queues them for the back end.
module cbsu_front #(
  parameter int DEPTH = cbsu_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  cbsu_pkg::request_t  request,
  output logic                full,
  input  logic                take,
  output cbsu_pkg::decoded_t  decoded,
  output logic                none
);

  cbsu_pkg::decoded_t dec;

  always_comb begin
    dec.is_load  = (cbsu_pkg::op_t'(request.op) == cbsu_pkg::OP_LOAD);
    dec.load_idx = request.reg_index;
    dec.load_val = request.reg_value;
    dec.group    = cbsu_pkg::group_t'(request.opcode[7:6]);
    dec.bitn     = request.opcode[5:3];
    dec.sel      = request.opcode[2:0];
    dec.is_mem   = (request.opcode[2:0] == cbsu_pkg::REG_MEM);
    dec.mem_data = request.mem_data;
  end

  cbsu_fifo #(
    .item_t (cbsu_pkg::decoded_t),
    .DEPTH  (DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (dec),
    .full    (full),
    .pop     (take),
    .rd_data (decoded),
    .empty   (none)
  );

endmodule

FILE: hdl/cbsu_back.sv
// Back end: register file, flags and the bit/shift datapath, one beat per cycle while the result queue has room.
module cbsu_back (
  input  logic               clk,
  input  logic               rst,
  input  cbsu_pkg::decoded_t decoded,
  input  logic               none,
  output logic               take,
  input  logic               out_full,
  output logic               out_push,
  output cbsu_pkg::result_t  out_data
);

  logic [7:0] regs [8];
  logic [3:0] flag_bits;

  logic [7:0] operand;
  logic [7:0] value;
  logic [3:0] fl;
  logic [4:0] cyc;
  logic [8:0] sh;
  logic       wr_en;
  logic [2:0] wr_idx;
  logic [7:0] wr_val;
  logic       mem_wr;
  logic [7:0] h_now;
  logic [7:0] l_now;

  assign take     = !none && !out_full;
  assign out_push = take;

  always_comb begin
    operand = decoded.is_mem ? decoded.mem_data : regs[decoded.sel];
    value   = operand;
    fl      = flag_bits;
    cyc     = decoded.is_mem ? cbsu_pkg::CYC_MEM : cbsu_pkg::CYC_REG;
    sh      = cbsu_pkg::shift_op(decoded.bitn, operand, flag_bits[cbsu_pkg::FLAG_C]);
    wr_en   = 1'b0;
    wr_idx  = decoded.sel;
    wr_val  = value;
    mem_wr  = 1'b0;
    if (decoded.is_load) begin
      cyc = cbsu_pkg::CYC_LOAD;
      if (decoded.load_idx == cbsu_pkg::REG_MEM) begin
        // flags take the upper nibble
        fl    = decoded.load_val[7:4];
        value = {decoded.load_val[7:4], 4'h0};
      end else begin
        value  = decoded.load_val;
        wr_en  = 1'b1;
        wr_idx = decoded.load_idx;
      end
    end else begin
      case (decoded.group)
        cbsu_pkg::GRP_SHIFT: begin
          value = sh[7:0];
          fl    = 4'h0;
          fl[cbsu_pkg::FLAG_C] = sh[8];
          fl[cbsu_pkg::FLAG_Z] = (sh[7:0] == 8'h00);
        end
        cbsu_pkg::GRP_BIT: begin
          fl[cbsu_pkg::FLAG_Z] = !operand[decoded.bitn];
          fl[cbsu_pkg::FLAG_N] = 1'b0;
          fl[cbsu_pkg::FLAG_H] = 1'b1;
          if (decoded.is_mem) begin
            cyc = cbsu_pkg::CYC_BIT_MEM;
          end
        end
        cbsu_pkg::GRP_RES: value = operand & ~(8'h01 << decoded.bitn);
        cbsu_pkg::GRP_SET: value = operand | (8'h01 << decoded.bitn);
        default: value = operand;
      endcase
      if (decoded.group != cbsu_pkg::GRP_BIT) begin
        mem_wr = decoded.is_mem;
        wr_en  = !decoded.is_mem;
      end
    end
    wr_val = value;
    h_now  = (wr_en && wr_idx == cbsu_pkg::REG_H) ? wr_val : regs[cbsu_pkg::REG_H];
    l_now  = (wr_en && wr_idx == cbsu_pkg::REG_L) ? wr_val : regs[cbsu_pkg::REG_L];

    out_data.result_value = value;
    out_data.flags        = fl;
    out_data.mem_write    = mem_wr;
    out_data.mem_address  = {h_now, l_now};
    out_data.cycles       = cyc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) begin
        regs[i] <= 8'h00;
      end
      flag_bits <= 4'h0;
    end else if (take) begin
      flag_bits <= fl;
      if (wr_en) begin
        regs[wr_idx] <= wr_val;
      end
    end
  end

endmodule

FILE: hdl/cbsu_checker.sv
// Port-level checks for the CB-prefix bit and shift unit, bound to the top level.
module cbsu_checker (
  input logic               clk,
  input logic               rst,
  input logic               empty,
  input logic               pop,
  input cbsu_pkg::result_t  result
);

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result shown right after reset");

  // a held result beat keeps its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("stalled result beat changed");

  // memory writes come only from non-BIT memory operations
  a_write_cost: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.mem_write) |-> (result.cycles == cbsu_pkg::CYC_MEM))
    else $error("memory write with wrong cost");

  a_mem_cost_write: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.cycles == cbsu_pkg::CYC_MEM) |-> result.mem_write)
    else $error("memory operation without write");

  a_cost_legal: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (result.cycles == cbsu_pkg::CYC_LOAD || result.cycles == cbsu_pkg::CYC_REG ||
                result.cycles == cbsu_pkg::CYC_BIT_MEM || result.cycles == cbsu_pkg::CYC_MEM))
    else $error("illegal cycle cost");

endmodule

bind cb_prefix_bit_shift_unit cbsu_checker u_cbsu_checker (
  .clk    (clk),
  .rst    (rst),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);
